/* hw/rtl/ovlt_pkg.sv */
`timescale 1ns / 1ps

package ovlt_pkg;

  // List depth and derived widths
  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OCC_W = $clog2(MAX_ENTRIES + 1);

  // Field widths of the channels
  localparam int OP_W  = 3;
  localparam int VAL_W = 32;
  localparam int POS_W = 4;
  localparam int CNT_W = 5;

  // Width that holds both a position and an occupancy for compares
  localparam int CMP_W = (OCC_W > POS_W) ? OCC_W : POS_W;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_FIND   = 3'd2,
    OP_READK  = 3'd3,
    OP_CLEAR  = 3'd4
  } opcode_t;

  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_SCAN_CMP  = 5'b00010,
    ST_SHIFT_WR  = 5'b00100,
    ST_READ_WAIT = 5'b01000,
    ST_RESP      = 5'b10000
  } state_t;

  // Entry store control: one write and one registered read per cycle
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } mem_ctl_t;

  // Outputs of the shared compare and index unit
  typedef struct packed {
    logic             eq;
    logic [IDX_W-1:0] idx_up;
    logic [IDX_W-1:0] idx_up2;
    logic [IDX_W-1:0] idx_dn;
    logic             at_top;
    logic             next_top;
  } step_res_t;

endpackage

/* hw/rtl/ovlt_ifs.sv */
`timescale 1ns / 1ps

// Command channel
interface ovlt_in_if;
  logic                                valid;
  logic                                ready;
  logic [ovlt_pkg::OP_W-1:0]           opcode;
  logic signed [ovlt_pkg::VAL_W-1:0]   value;
  logic [ovlt_pkg::POS_W-1:0]          position;

  modport source (output valid, output opcode, output value, output position, input ready);
  modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface

// Result channel
interface ovlt_out_if;
  logic                                valid;
  logic                                ready;
  logic                                ok;
  logic signed [ovlt_pkg::VAL_W-1:0]   data;
  logic                                empty_res;
  logic [ovlt_pkg::CNT_W-1:0]          count;

  modport source (output valid, output ok, output data, output empty_res, output count,
                  input ready);
  modport sink   (input valid, input ok, input data, input empty_res, input count,
                  output ready);
endinterface

/* hw/rtl/ordered_value_list_table_unit.sv */
`timescale 1ns / 1ps

// Bounded ordered list of signed 32-bit values, up to 16 entries, front first.
// in_ch carries one command per transfer (insert front, delete first match,
// find, read kth, clear); out_ch returns one result per command with ok, data,
// empty_res and count. One command is worked on at a time: in_ch.ready is high
// only while the sequencer is idle.
// Insert, clear and any early failure go straight to the response state; read
// kth first waits for the registered store read. Find and delete scan the
// entries one per cycle through a single shared comparator, front to back, and
// stop at the first match or after the back entry. A delete then moves each
// entry ahead of the match down one slot to close the gap. The store serves
// one read per cycle. The next command can be taken at the earliest in the
// cycle after the result of the previous one is loaded.
// Reset empties the list and clears the result valid flag; entries are not
// cleared. A finished result waits in the result register while out_ch.ready
// is low; the next command is taken meanwhile, and its result waits in the
// sequencer until the register frees up.
module ordered_value_list_table_unit (
  input  logic        clk,
  input  logic        rst_n,
  ovlt_in_if.sink     in_ch,
  ovlt_out_if.source  out_ch
);

  ovlt_pkg::mem_ctl_t              mem_ctl;
  logic [ovlt_pkg::VAL_W-1:0]      rd_data;
  logic [ovlt_pkg::IDX_W-1:0]      idx;
  logic [ovlt_pkg::OCC_W-1:0]      occ;
  logic [ovlt_pkg::VAL_W-1:0]      key;
  ovlt_pkg::step_res_t             st;

  ovlt_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .mem_ctl (mem_ctl),
    .rd_data (rd_data),
    .idx     (idx),
    .occ     (occ),
    .key     (key),
    .st      (st)
  );

  ovlt_step u_step (
    .idx     (idx),
    .occ     (occ),
    .rd_data (rd_data),
    .key     (key),
    .res     (st)
  );

  ovlt_store u_store (
    .clk     (clk),
    .ctl     (mem_ctl),
    .rd_data (rd_data)
  );

endmodule

/* hw/rtl/ovlt_store.sv */
`timescale 1ns / 1ps

// Entry storage: physical slot 0 holds the back of the list, slot occ-1 the front
module ovlt_store (
  input  logic                            clk,
  input  ovlt_pkg::mem_ctl_t              ctl,
  output logic [ovlt_pkg::VAL_W-1:0]      rd_data
);

  logic [ovlt_pkg::VAL_W-1:0] mem_r [ovlt_pkg::MAX_ENTRIES];
  logic [ovlt_pkg::VAL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem_r[ctl.waddr] <= ctl.wdata;
    end
    rd_data_r <= mem_r[ctl.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/ovlt_step.sv */
`timescale 1ns / 1ps

// Shared compare and index unit used by every scan and shift step
module ovlt_step (
  input  logic [ovlt_pkg::IDX_W-1:0]  idx,
  input  logic [ovlt_pkg::OCC_W-1:0]  occ,
  input  logic [ovlt_pkg::VAL_W-1:0]  rd_data,
  input  logic [ovlt_pkg::VAL_W-1:0]  key,
  output ovlt_pkg::step_res_t         res
);

  logic [ovlt_pkg::OCC_W-1:0] idx_ext;

  assign idx_ext = ovlt_pkg::OCC_W'(idx);

  always_comb begin
    res.eq       = (rd_data == key);
    res.idx_up   = idx + ovlt_pkg::IDX_W'(1);
    res.idx_up2  = idx + ovlt_pkg::IDX_W'(2);
    res.idx_dn   = idx - ovlt_pkg::IDX_W'(1);
    // slot is the front entry
    res.at_top   = ((idx_ext + ovlt_pkg::OCC_W'(1)) == occ);
    // next slot is the front entry
    res.next_top = ((idx_ext + ovlt_pkg::OCC_W'(2)) == occ);
  end

endmodule

/* hw/rtl/ovlt_seq.sv */
`timescale 1ns / 1ps

// Operation sequencer: accepts one command, steps the store, loads the result register
module ovlt_seq (
  input  logic                            clk,
  input  logic                            rst_n,
  ovlt_in_if.sink                         in_ch,
  ovlt_out_if.source                      out_ch,
  output ovlt_pkg::mem_ctl_t              mem_ctl,
  input  logic [ovlt_pkg::VAL_W-1:0]      rd_data,
  output logic [ovlt_pkg::IDX_W-1:0]      idx,
  output logic [ovlt_pkg::OCC_W-1:0]      occ,
  output logic [ovlt_pkg::VAL_W-1:0]      key,
  input  ovlt_pkg::step_res_t             st
);

  ovlt_pkg::state_t            state_r,    state_nxt;
  ovlt_pkg::opcode_t           op_r,       op_nxt;
  logic [ovlt_pkg::VAL_W-1:0]  key_r,      key_nxt;
  logic [ovlt_pkg::IDX_W-1:0]  idx_r,      idx_nxt;
  logic [ovlt_pkg::OCC_W-1:0]  occ_r,      occ_nxt;
  logic                        res_ok_r,   res_ok_nxt;
  logic [ovlt_pkg::VAL_W-1:0]  res_data_r, res_data_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_ok_r,   out_ok_nxt;
  logic [ovlt_pkg::VAL_W-1:0]  out_data_r, out_data_nxt;
  logic                        out_empty_r, out_empty_nxt;
  logic [ovlt_pkg::CNT_W-1:0]  out_count_r, out_count_nxt;

  ovlt_pkg::opcode_t           in_op;
  logic [ovlt_pkg::CMP_W-1:0]  pos_ext;
  logic [ovlt_pkg::CMP_W-1:0]  occ_ext;
  logic [ovlt_pkg::CMP_W-1:0]  kth_slot;
  logic [ovlt_pkg::OCC_W-1:0]  occ_dn;

  assign in_op    = ovlt_pkg::opcode_t'(in_ch.opcode);
  assign pos_ext  = ovlt_pkg::CMP_W'(in_ch.position);
  assign occ_ext  = ovlt_pkg::CMP_W'(occ_r);
  // front is the top slot, so position k lives at slot occ-1-k
  assign kth_slot = occ_ext - ovlt_pkg::CMP_W'(1) - pos_ext;
  assign occ_dn   = occ_r - ovlt_pkg::OCC_W'(1);

  assign in_ch.ready      = (state_r == ovlt_pkg::ST_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.ok        = out_ok_r;
  assign out_ch.data      = out_data_r;
  assign out_ch.empty_res = out_empty_r;
  assign out_ch.count     = out_count_r;

  assign idx = idx_r;
  assign occ = occ_r;
  assign key = key_r;

  // Next-state and store control
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    idx_nxt       = idx_r;
    occ_nxt       = occ_r;
    res_ok_nxt    = res_ok_r;
    res_data_nxt  = res_data_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_data_nxt  = out_data_r;
    out_empty_nxt = out_empty_r;
    out_count_nxt = out_count_r;
    mem_ctl       = '0;
    mem_ctl.raddr = idx_r;

    // result register drains on its transfer
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ovlt_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          op_nxt       = in_op;
          key_nxt      = in_ch.value;
          res_ok_nxt   = 1'b0;
          res_data_nxt = '0;
          state_nxt    = ovlt_pkg::ST_RESP;
          case (in_op)
            ovlt_pkg::OP_INSERT: begin
              if (occ_r != ovlt_pkg::OCC_W'(ovlt_pkg::MAX_ENTRIES)) begin
                mem_ctl.we    = 1'b1;
                mem_ctl.waddr = occ_r[ovlt_pkg::IDX_W-1:0];
                mem_ctl.wdata = in_ch.value;
                occ_nxt       = occ_r + ovlt_pkg::OCC_W'(1);
                res_ok_nxt    = 1'b1;
              end
            end
            ovlt_pkg::OP_DELETE, ovlt_pkg::OP_FIND: begin
              // scan starts at the front slot
              if (occ_r != '0) begin
                idx_nxt       = occ_dn[ovlt_pkg::IDX_W-1:0];
                mem_ctl.raddr = occ_dn[ovlt_pkg::IDX_W-1:0];
                state_nxt     = ovlt_pkg::ST_SCAN_CMP;
              end
            end
            ovlt_pkg::OP_READK: begin
              if (pos_ext < occ_ext) begin
                mem_ctl.raddr = kth_slot[ovlt_pkg::IDX_W-1:0];
                state_nxt     = ovlt_pkg::ST_READ_WAIT;
              end
            end
            ovlt_pkg::OP_CLEAR: begin
              res_ok_nxt = (occ_r != '0);
              occ_nxt    = '0;
            end
            default: begin
              res_ok_nxt = 1'b0;
            end
          endcase
        end
      end

      ovlt_pkg::ST_SCAN_CMP: begin
        if (st.eq) begin
          res_ok_nxt = 1'b1;
          if (op_r == ovlt_pkg::OP_DELETE) begin
            if (st.at_top) begin
              occ_nxt   = occ_dn;
              state_nxt = ovlt_pkg::ST_RESP;
            end else begin
              // close the gap: pull entries from the front side down one slot
              mem_ctl.raddr = st.idx_up;
              state_nxt     = ovlt_pkg::ST_SHIFT_WR;
            end
          end else begin
            state_nxt = ovlt_pkg::ST_RESP;
          end
        end else if (idx_r == '0) begin
          state_nxt = ovlt_pkg::ST_RESP;
        end else begin
          idx_nxt       = st.idx_dn;
          mem_ctl.raddr = st.idx_dn;
        end
      end

      ovlt_pkg::ST_SHIFT_WR: begin
        mem_ctl.we    = 1'b1;
        mem_ctl.waddr = idx_r;
        mem_ctl.wdata = rd_data;
        if (st.next_top) begin
          occ_nxt   = occ_dn;
          state_nxt = ovlt_pkg::ST_RESP;
        end else begin
          idx_nxt       = st.idx_up;
          mem_ctl.raddr = st.idx_up2;
        end
      end

      ovlt_pkg::ST_READ_WAIT: begin
        res_ok_nxt   = 1'b1;
        res_data_nxt = rd_data;
        state_nxt    = ovlt_pkg::ST_RESP;
      end

      ovlt_pkg::ST_RESP: begin
        // load the result register once it is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_data_nxt  = res_data_r;
          out_empty_nxt = (occ_r == '0);
          out_count_nxt = ovlt_pkg::CNT_W'(occ_r);
          state_nxt     = ovlt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = ovlt_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ovlt_pkg::ST_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    idx_r       <= idx_nxt;
    res_ok_r    <= res_ok_nxt;
    res_data_r  <= res_data_nxt;
    out_ok_r    <= out_ok_nxt;
    out_data_r  <= out_data_nxt;
    out_empty_r <= out_empty_nxt;
    out_count_r <= out_count_nxt;
  end

endmodule

/* hw/rtl/ovlt_chk.sv */
`timescale 1ns / 1ps

// Port-level checks on the list unit
module ovlt_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_ok,
  input logic [ovlt_pkg::VAL_W-1:0]    out_data,
  input logic                          out_empty_res,
  input logic [ovlt_pkg::CNT_W-1:0]    out_count
);

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one command at a time: busy after a command transfer
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("command taken while busy");

  // empty flag agrees with count
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_empty_res == (out_count == '0)))
    else $error("empty_res disagrees with count");

  // failed operations return zero data
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_data == '0))
    else $error("nonzero data on failure");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data) && $stable(out_count)))
    else $error("stalled result changed");

endmodule

bind ordered_value_list_table_unit ovlt_chk u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_ok        (out_ch.ok),
  .out_data      (out_ch.data),
  .out_empty_res (out_ch.empty_res),
  .out_count     (out_ch.count)
);

/* verif/tb_ordered_value_list_table_unit.sv */
`timescale 1ns / 1ps

module tb_ordered_value_list_table_unit;

  // Reserved opcodes: the block fails them and leaves the list unchanged
  localparam logic [ovlt_pkg::OP_W-1:0] OP_RSVD_LO = 3'd5;
  localparam logic [ovlt_pkg::OP_W-1:0] OP_RSVD_HI = 3'd7;

  localparam logic signed [ovlt_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [ovlt_pkg::VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  localparam int RANDOM_CMDS = 1000;

  typedef struct {
    logic                              ok;
    logic signed [ovlt_pkg::VAL_W-1:0] data;
    logic                              empty_res;
    logic [ovlt_pkg::CNT_W-1:0]        count;
  } list_result_t;

  typedef struct {
    logic [ovlt_pkg::OP_W-1:0]         op;
    logic signed [ovlt_pkg::VAL_W-1:0] value;
    logic [ovlt_pkg::POS_W-1:0]        pos;
    int                                reps;
    bit                                fixed;
    list_result_t                      res;
  } cmd_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic steady;

  ovlt_in_if  in_ch ();
  ovlt_out_if out_ch ();

  ordered_value_list_table_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the list, front first
  logic signed [ovlt_pkg::VAL_W-1:0] shadow_list [ovlt_pkg::MAX_ENTRIES];
  int                                shadow_occ;

  list_result_t pending_results [$];
  cmd_row_t     directed_rows [$];
  int           mismatch_cnt = 0;

  always #6 clk = ~clk;

  // Apply one command to the shadow list and return the result it yields
  function automatic list_result_t predict_list_op(
      input logic [ovlt_pkg::OP_W-1:0] op,
      input logic signed [ovlt_pkg::VAL_W-1:0] v,
      input logic [ovlt_pkg::POS_W-1:0] pos);
    list_result_t r;
    int           i;
    int           hit;
    r.ok   = 1'b0;
    r.data = '0;
    hit    = shadow_occ;
    for (i = shadow_occ - 1; i >= 0; i--) begin
      if (shadow_list[i] == v) hit = i;
    end
    case (op)
      ovlt_pkg::OP_INSERT: begin
        if (shadow_occ < ovlt_pkg::MAX_ENTRIES) begin
          for (i = shadow_occ; i > 0; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[0] = v;
          shadow_occ++;
          r.ok = 1'b1;
        end
      end
      ovlt_pkg::OP_DELETE: begin
        // close the gap behind the first match
        if (hit < shadow_occ) begin
          for (i = hit; i + 1 < shadow_occ; i++) shadow_list[i] = shadow_list[i+1];
          shadow_occ--;
          r.ok = 1'b1;
        end
      end
      ovlt_pkg::OP_FIND: r.ok = (hit < shadow_occ);
      ovlt_pkg::OP_READK: begin
        if (int'(pos) < shadow_occ) begin
          r.data = shadow_list[pos];
          r.ok   = 1'b1;
        end
      end
      ovlt_pkg::OP_CLEAR: begin
        if (shadow_occ != 0) begin
          shadow_occ = 0;
          r.ok       = 1'b1;
        end
      end
      default: ;
    endcase
    r.empty_res = (shadow_occ == 0);
    r.count     = shadow_occ[ovlt_pkg::CNT_W-1:0];
    return r;
  endfunction

  function automatic list_result_t mk_res(input logic ok,
                                          input logic signed [ovlt_pkg::VAL_W-1:0] data,
                                          input logic empty_res,
                                          input logic [ovlt_pkg::CNT_W-1:0] count);
    list_result_t r;
    r.ok        = ok;
    r.data      = data;
    r.empty_res = empty_res;
    r.count     = count;
    return r;
  endfunction

  function automatic void add_row(input logic [ovlt_pkg::OP_W-1:0] op,
                                  input logic signed [ovlt_pkg::VAL_W-1:0] value,
                                  input logic [ovlt_pkg::POS_W-1:0] pos, input int reps,
                                  input bit fixed, input list_result_t res);
    cmd_row_t row;
    row.op    = op;
    row.value = value;
    row.pos   = pos;
    row.reps  = reps;
    row.fixed = fixed;
    row.res   = res;
    directed_rows.push_back(row);
  endfunction

  // Present one command, hold it until the transfer, then queue its expected result.
  // Called at a rising edge; returns at the edge of the transfer.
  task automatic send_cmd(input logic [ovlt_pkg::OP_W-1:0] op,
                          input logic signed [ovlt_pkg::VAL_W-1:0] v,
                          input logic [ovlt_pkg::POS_W-1:0] pos, input bit fixed,
                          input list_result_t fixed_res);
    list_result_t pred;
    if (!steady) begin
      while ($urandom_range(99) < 35) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.value    <= v;
    in_ch.position <= pos;
    do @(posedge clk); while (!in_ch.ready);
    pred = predict_list_op(op, v, pos);
    pending_results.push_back(fixed ? fixed_res : pred);
  endtask

  // Result side stalls at random outside the steady phase
  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= 35);
  end

  // Compare every result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    list_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result ok=%0b data=%0d empty=%0b count=%0d", $time,
                 out_ch.ok, out_ch.data, out_ch.empty_res, out_ch.count);
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.ok !== want.ok || out_ch.data !== want.data ||
            out_ch.empty_res !== want.empty_res || out_ch.count !== want.count) begin
          $display("%0t: expected ok=%0b data=%0d empty=%0b count=%0d", $time,
                   want.ok, want.data, want.empty_res, want.count);
          $display("%0t: actual   ok=%0b data=%0d empty=%0b count=%0d", $time,
                   out_ch.ok, out_ch.data, out_ch.empty_res, out_ch.count);
          mismatch_cnt++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    list_result_t                      nores;
    logic [ovlt_pkg::OP_W-1:0]         op;
    logic signed [ovlt_pkg::VAL_W-1:0] v;
    logic [ovlt_pkg::POS_W-1:0]        pos;
    int                                n;
    int                                k;
    int                                roll;
    bit                                filling;

    rst_n          <= 1'b0;
    steady         <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.opcode   <= ovlt_pkg::OP_INSERT;
    in_ch.value    <= '0;
    in_ch.position <= '0;
    shadow_occ     = 0;
    nores          = mk_res(1'b0, '0, 1'b1, '0);

    // Directed table: empty list, extremes, full list, deletes at front, next to back and back, a miss
    add_row(ovlt_pkg::OP_FIND,   0,       4'd0, 1, 1'b1, mk_res(1'b0, 0, 1'b1, 5'd0));
    add_row(ovlt_pkg::OP_READK,  0,       4'd0, 1, 1'b1, mk_res(1'b0, 0, 1'b1, 5'd0));
    add_row(ovlt_pkg::OP_DELETE, 5,       4'd0, 1, 1'b1, mk_res(1'b0, 0, 1'b1, 5'd0));
    add_row(ovlt_pkg::OP_CLEAR,  0,       4'd0, 1, 1'b1, mk_res(1'b0, 0, 1'b1, 5'd0));
    add_row(OP_RSVD_LO, 32'h1234_5678,   4'd15, 1, 1'b1, mk_res(1'b0, 0, 1'b1, 5'd0));
    add_row(ovlt_pkg::OP_INSERT, VAL_MIN, 4'd0, 1, 1'b1, mk_res(1'b1, 0, 1'b0, 5'd1));
    add_row(ovlt_pkg::OP_INSERT, VAL_MAX, 4'd0, 1, 1'b1, mk_res(1'b1, 0, 1'b0, 5'd2));
    add_row(ovlt_pkg::OP_READK,  0,       4'd0, 1, 1'b1,
            mk_res(1'b1, VAL_MAX, 1'b0, 5'd2));
    add_row(ovlt_pkg::OP_READK,  0,       4'd1, 1, 1'b1,
            mk_res(1'b1, VAL_MIN, 1'b0, 5'd2));
    add_row(ovlt_pkg::OP_READK,  0,       4'd2, 1, 1'b1, mk_res(1'b0, 0, 1'b0, 5'd2));
    add_row(ovlt_pkg::OP_INSERT, 0,       4'd0, 1,  1'b0, nores);
    add_row(ovlt_pkg::OP_INSERT, -1,      4'd0, 1,  1'b0, nores);
    add_row(ovlt_pkg::OP_INSERT, 7,       4'd0, 12, 1'b0, nores);
    add_row(ovlt_pkg::OP_INSERT, 99,      4'd0, 1, 1'b1, mk_res(1'b0, 0, 1'b0, 5'd16));
    add_row(ovlt_pkg::OP_READK,  0,       4'd15, 1, 1'b1,
            mk_res(1'b1, VAL_MIN, 1'b0, 5'd16));
    add_row(OP_RSVD_HI,          -1,      4'd0, 1, 1'b1, mk_res(1'b0, 0, 1'b0, 5'd16));
    add_row(ovlt_pkg::OP_FIND,   VAL_MIN, 4'd0, 1, 1'b0, nores);
    add_row(ovlt_pkg::OP_DELETE, VAL_MAX, 4'd0, 1, 1'b0, nores);
    add_row(ovlt_pkg::OP_DELETE, 7,       4'd0, 1, 1'b0, nores);
    add_row(ovlt_pkg::OP_DELETE, 12345,   4'd0, 1, 1'b0, nores);
    add_row(ovlt_pkg::OP_DELETE, VAL_MIN, 4'd0, 1, 1'b0, nores);
    add_row(ovlt_pkg::OP_CLEAR,  0,       4'd0, 1, 1'b1, mk_res(1'b1, 0, 1'b1, 5'd0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      for (k = 0; k < directed_rows[r].reps; k++) begin
        send_cmd(directed_rows[r].op, directed_rows[r].value, directed_rows[r].pos,
                 directed_rows[r].fixed, directed_rows[r].res);
      end
    end

    // Random commands: alternating fill and drain phases, values mostly
    // drawn from the list itself or a small pool so deletes and finds hit
    for (n = 0; n < RANDOM_CMDS; n++) begin
      if (n == 400) steady <= 1'b1;
      if (n == 600) steady <= 1'b0;
      filling = ((n / 100) % 2) == 0;
      roll = $urandom_range(99);
      if (roll < 2)                    op = ovlt_pkg::OP_W'($urandom_range(OP_RSVD_LO,
                                                                           OP_RSVD_HI));
      else if (roll < 5)               op = ovlt_pkg::OP_CLEAR;
      else if (roll < (filling ? 50 : 25)) op = ovlt_pkg::OP_INSERT;
      else if (roll < (filling ? 65 : 60)) op = ovlt_pkg::OP_DELETE;
      else if (roll < 82)              op = ovlt_pkg::OP_FIND;
      else                             op = ovlt_pkg::OP_READK;

      roll = $urandom_range(99);
      if (roll < 40 && shadow_occ > 0) v = shadow_list[$urandom_range(shadow_occ - 1)];
      else if (roll < 70)              v = $signed($urandom_range(15)) - 8;
      else if (roll < 90)              v = $urandom;
      else begin
        case ($urandom_range(3))
          0:       v = VAL_MIN;
          1:       v = VAL_MAX;
          2:       v = 0;
          default: v = -1;
        endcase
      end

      if ($urandom_range(99) < 70) begin
        pos = ovlt_pkg::POS_W'($urandom_range(shadow_occ > 0 ? shadow_occ - 1 : 0));
      end else begin
        pos = ovlt_pkg::POS_W'($urandom_range(15));
      end

      send_cmd(op, v, pos, 1'b0, nores);
    end
    in_ch.valid <= 1'b0;

    // Drain, then watch a while for stray results
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
